>>> rtl/rwca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rwca_pkg
// Shared widths, codes and types of the reorder window with cumulative ack.
// ----------------------------------------------------------------------------
package rwca_pkg;

   localparam int SEQ_W            = 31;
   localparam int TS_W             = 32;
   localparam int MODE_W           = 2;
   localparam int KIND_W           = 2;
   localparam int REQ_DATA_W       = 64;
   localparam int DEF_WINDOW_SLOTS = 16;

   localparam logic [SEQ_W-1:0] INIT_EXPECTED_SEQ = 31'd111;

   // request modes
   localparam logic [MODE_W-1:0] MODE_DATA    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PROBE   = 2'd2;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_ACK     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CONSUME = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PROBE   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLACE,
      ST_REPLY
   } state_type;

endpackage

>>> rtl/reorder_window_cumulative_ack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_window_cumulative_ack
// Receive window with out-of-order placement and cumulative acknowledgement.
// ----------------------------------------------------------------------------
// Each item is taken in one cycle, placed in the slot ring during the next,
// and its reply is built in the cycle after that, which is also the cycle in
// which the following item may be taken if the output register can load, so
// a new item is taken only once the previous one is placed. This pacing is
// set by the slot sequence memory: placement writes it and reads the walk end
// and tail slot back into registers for the reply. The ack pointer moves over
// the run of filled slots (one slot only with the window full) in that single
// placement cycle through a priority search on the valid bits. A reply waits
// in an output register, so the next item is still taken while rsp_tready is
// low, until a second reply would be due. A csr write sets the expected
// sequence number, except in the reply cycle, where the ack update wins.
module reorder_window_cumulative_ack
   import rwca_pkg::*;
#(
   parameter int WINDOW_SLOTS = DEF_WINDOW_SLOTS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [SEQ_W-1:0]        csr_wdata,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // seq_number [30:0], timestamp [62:31], zero pad [63]
   input  logic [REQ_DATA_W-1:0]   req_tdata,
   // mode [1:0]
   input  logic [MODE_W-1:0]       req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // ack_seq, advertised_window, echo_timestamp, dropped_no_space, duplicate,
   // removed, removed_seq, zero pad (default: [30:0] [35:31] [67:36] [68]
   // [69] [70] [101:71] [103:102])
   output logic [((2 * SEQ_W + TS_W + 3 + $clog2(WINDOW_SLOTS + 1) + 7) / 8) * 8 - 1:0]
                                   rsp_tdata,
   // kind [1:0]
   output logic [KIND_W-1:0]       rsp_tuser
);

   localparam int IDX_W      = $clog2(WINDOW_SLOTS);
   localparam int CNT_W      = $clog2(WINDOW_SLOTS + 1);
   localparam int ADV_W      = CNT_W;
   localparam int RSP_BITS   = 2 * SEQ_W + TS_W + 3 + ADV_W;
   localparam int RSP_DATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RECIP_SH   = SEQ_W + IDX_W;
   // floor(2^RECIP_SH / slots): quotient estimate is low by at most one
   localparam logic [63:0] RECIP = (64'd1 << RECIP_SH) / 64'(WINDOW_SLOTS);
   localparam logic [CNT_W-1:0] SLOTS_C = CNT_W'(WINDOW_SLOTS);

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
      if (s >= (CNT_W + 1)'(WINDOW_SLOTS)) s = s - (CNT_W + 1)'(WINDOW_SLOTS);
      return IDX_W'(s);
   endfunction

   // control state
   state_type               state_ff, state_in;
   logic [WINDOW_SLOTS-1:0] valid_ff;
   logic [IDX_W-1:0]        head_ff, tail_ff, ack_ff;
   logic [CNT_W-1:0]        free_ff;
   logic [SEQ_W-1:0]        expected_ff;
   logic                    walk_moved_ff;
   logic                    rsp_valid_ff;

   // item registers
   logic [MODE_W-1:0]       mode_ff;
   logic [SEQ_W-1:0]        seq_ff;
   logic [TS_W-1:0]         ts_ff;
   logic                    gt_ff, lt_ff;
   logic [SEQ_W-1:0]        delta_ff, back_ff, q0_ff;
   logic [SEQ_W-1:0]        head_seq_ff;
   logic                    drop_ff, dup_ff, rem_ff, rem_valid_ff;
   logic                    fwd_a_ff, fwd_b_ff;
   logic [SEQ_W-1:0]        rd_a_ff, rd_b_ff;
   logic [RSP_DATA_W-1:0]   rsp_data_ff;
   logic [KIND_W-1:0]       rsp_kind_ff;

   logic [SEQ_W-1:0]        slot_seq_mem [WINDOW_SLOTS];

   // handshake and sequencing
   logic                    req_acc, can_load, rsp_load, place_en;

   // placement results
   logic                    we;
   logic [IDX_W-1:0]        widx, head_in, tail_in, ack_in, addr_a, addr_b;
   logic [WINDOW_SLOTS-1:0] valid_in;
   logic [CNT_W-1:0]        free_in, steps;
   logic                    hs_we, drop, dup, rem, rem_valid;

   // stage one and reply values
   logic [SEQ_W-1:0]        req_seq, expected_cur, data_a, data_b, back_in;
   logic [63:0]             prod;
   logic [ADV_W-1:0]        adv;
   logic [SEQ_W-1:0]        removed_seq;
   logic [TS_W-1:0]         echo;
   logic [KIND_W-1:0]       kind;

   assign req_seq      = req_tdata[SEQ_W-1:0];
   assign req_acc      = req_tvalid && req_tready;
   assign can_load     = !rsp_valid_ff || rsp_tready;
   assign data_a       = fwd_a_ff ? seq_ff : rd_a_ff;
   assign data_b       = fwd_b_ff ? seq_ff : rd_b_ff;
   assign expected_cur = walk_moved_ff ? data_a + SEQ_W'(1) : expected_ff;
   assign back_in      = head_seq_ff - req_seq;
   assign prod         = 64'(back_in) * RECIP;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_tuser <= MODE_PROBE) state_in = ST_PLACE;
         end
         ST_PLACE: begin
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (can_load) begin
               state_in = (req_acc && req_tuser <= MODE_PROBE) ? ST_PLACE : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencing outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_load   = 1'b0;
      place_en   = 1'b0;
      case (state_ff)
         ST_IDLE:  req_tready = 1'b1;
         ST_PLACE: place_en   = 1'b1;
         ST_REPLY: begin
            req_tready = can_load;
            rsp_load   = can_load;
         end
         default: ;
      endcase
   end

   // placement and ack walk
   always_comb begin : place_logic
      logic [SEQ_W-1:0]        qn, r0, r1;
      logic [IDX_W-1:0]        bidx, end_idx;
      logic [WINDOW_SLOTS-1:0] rot;
      logic [CNT_W-1:0]        run;
      logic                    walk_en;

      we        = 1'b0;
      widx      = head_ff;
      valid_in  = valid_ff;
      free_in   = free_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      hs_we     = 1'b0;
      walk_en   = 1'b0;
      drop      = 1'b0;
      dup       = 1'b0;
      rem       = 1'b0;
      rem_valid = 1'b0;

      // backward offset from head, modulo the slot count
      qn   = SEQ_W'(q0_ff * SEQ_W'(WINDOW_SLOTS));
      r0   = back_ff - qn;
      r1   = (r0 >= SEQ_W'(WINDOW_SLOTS)) ? r0 - SEQ_W'(WINDOW_SLOTS) : r0;
      bidx = wrap_add(head_ff, SLOTS_C - CNT_W'(r1));

      case (mode_ff)
         MODE_DATA: begin
            if (free_ff == SLOTS_C) begin
               widx    = wrap_add(head_ff, CNT_W'(1));
               we      = 1'b1;
               head_in = widx;
               hs_we   = 1'b1;
               free_in = SLOTS_C - CNT_W'(1);
               walk_en = 1'b1;
            end else if (gt_ff) begin
               if (delta_ff > SEQ_W'(free_ff)) begin
                  drop = 1'b1;
               end else begin
                  free_in = free_ff - CNT_W'(delta_ff);
                  head_in = wrap_add(head_ff, CNT_W'(delta_ff));
                  widx    = head_in;
                  we      = 1'b1;
                  hs_we   = 1'b1;
                  walk_en = 1'b1;
               end
            end else if (lt_ff) begin
               dup     = 1'b1;
               walk_en = 1'b1;
            end else begin
               widx    = bidx;
               we      = !valid_ff[bidx];
               hs_we   = !valid_ff[bidx] && (bidx == head_ff);
               walk_en = 1'b1;
            end
            if (we) valid_in[widx] = 1'b1;
         end
         MODE_CONSUME: begin
            if (free_ff != SLOTS_C) begin
               rem             = 1'b1;
               rem_valid       = valid_ff[tail_ff];
               valid_in[tail_ff] = 1'b0;
               tail_in         = wrap_add(tail_ff, CNT_W'(1));
               free_in         = free_ff + CNT_W'(1);
            end
         end
         default: ;
      endcase

      // length of the filled run starting at the ack pointer
      for (int i = 0; i < WINDOW_SLOTS; i++) begin
         rot[i] = valid_in[wrap_add(ack_ff, CNT_W'(i))];
      end
      run = SLOTS_C;
      for (int i = WINDOW_SLOTS - 1; i >= 0; i--) begin
         if (!rot[i]) run = CNT_W'(i);
      end

      if (!walk_en) steps = '0;
      else if (free_in == '0) steps = CNT_W'(rot[0]);
      else steps = run;

      end_idx = (steps == '0) ? ack_ff : wrap_add(ack_ff, steps - CNT_W'(1));
      ack_in  = wrap_add(ack_ff, steps);
      addr_a  = (mode_ff == MODE_CONSUME) ? tail_ff : end_idx;
      addr_b  = tail_in;
   end

   // reply fields
   always_comb begin : reply_logic
      logic signed [SEQ_W+1:0] gap, room;

      gap  = $signed({2'b00, expected_cur}) - $signed({2'b00, data_b});
      room = $signed((SEQ_W + 2)'(WINDOW_SLOTS)) - gap;
      if (!valid_ff[tail_ff]) adv = ADV_W'(WINDOW_SLOTS);
      else if (room < 0) adv = '0;
      else if (room > $signed((SEQ_W + 2)'(WINDOW_SLOTS))) adv = ADV_W'(WINDOW_SLOTS);
      else adv = ADV_W'(room);

      case (mode_ff)
         MODE_DATA:    kind = KIND_ACK;
         MODE_CONSUME: kind = KIND_CONSUME;
         default:      kind = KIND_PROBE;
      endcase
      echo        = (mode_ff == MODE_DATA) ? ts_ff : '0;
      removed_seq = (rem_ff && rem_valid_ff) ? data_a : '0;
   end

   // slot sequence memory, written and read back in the placement cycle
   always_ff @(posedge clock) begin
      if (place_en) begin
         if (we) slot_seq_mem[widx] <= seq_ff;
         rd_a_ff <= slot_seq_mem[addr_a];
         rd_b_ff <= slot_seq_mem[addr_b];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         head_ff       <= IDX_W'(WINDOW_SLOTS - 1);
         tail_ff       <= '0;
         ack_ff        <= '0;
         free_ff       <= SLOTS_C;
         expected_ff   <= INIT_EXPECTED_SEQ;
         walk_moved_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) expected_ff <= csr_wdata;
         if (place_en) begin
            valid_ff      <= valid_in;
            head_ff       <= head_in;
            tail_ff       <= tail_in;
            ack_ff        <= ack_in;
            free_ff       <= free_in;
            walk_moved_ff <= (steps != '0);
         end
         if (state_ff == ST_REPLY) begin
            expected_ff   <= expected_cur;
            walk_moved_ff <= 1'b0;
         end
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         mode_ff  <= req_tuser;
         seq_ff   <= req_seq;
         ts_ff    <= req_tdata[SEQ_W +: TS_W];
         gt_ff    <= req_seq > head_seq_ff;
         lt_ff    <= req_seq < expected_cur;
         delta_ff <= req_seq - head_seq_ff;
         back_ff  <= back_in;
         q0_ff    <= SEQ_W'(prod >> RECIP_SH);
      end
      if (place_en) begin
         if (hs_we) head_seq_ff <= seq_ff;
         drop_ff      <= drop;
         dup_ff       <= dup;
         rem_ff       <= rem;
         rem_valid_ff <= rem_valid;
         fwd_a_ff     <= we && (widx == addr_a);
         fwd_b_ff     <= we && (widx == addr_b);
      end
      if (rsp_load) begin
         rsp_kind_ff <= kind;
         rsp_data_ff <= RSP_DATA_W'({removed_seq, rem_ff, dup_ff, drop_ff, echo, adv,
                                     expected_cur});
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   // no item is taken while a placement is in flight
   a_no_take_in_place: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PLACE |-> !req_tready)
      else $error("item taken during placement");

   // a reply loaded in the reply cycle becomes valid in the output register
   a_reply_source: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff)
      else $error("reply lost at output register");

   // a dropped arrival leaves the window untouched
   a_drop_keeps_window: assert property (@(posedge clock) disable iff (reset)
      (place_en && drop) |=> (free_ff == $past(free_ff)) && (head_ff == $past(head_ff)))
      else $error("dropped arrival changed the window");

   // free count stays within the ring
   a_free_range: assert property (@(posedge clock) disable iff (reset)
      place_en |-> free_in <= SLOTS_C)
      else $error("free slot count out of range");

endmodule

>>> verif/reorder_window_cumulative_ack_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_window_cumulative_ack_tb
// Self-checking bench for the receive reorder window. A behavioral copy of the
// slot ring predicts every reply. Directed cases cover the corner cases and
// random traffic with random back-pressure covers the rest. Each reply is
// compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module reorder_window_cumulative_ack_tb;
   import rwca_pkg::*;

   localparam int SLOTS         = DEF_WINDOW_SLOTS;
   localparam int WIN_W         = $clog2(SLOTS + 1);
   localparam int RSP_W         = ((2 * SEQ_W + TS_W + 3 + WIN_W + 7) / 8) * 8;
   localparam int OFS_WIN       = SEQ_W;
   localparam int OFS_ECHO      = OFS_WIN + WIN_W;
   localparam int OFS_DROP      = OFS_ECHO + TS_W;
   localparam int OFS_DUP       = OFS_DROP + 1;
   localparam int OFS_REMOVED   = OFS_DROP + 2;
   localparam int OFS_RSEQ      = OFS_DROP + 3;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int REPORT_MAX    = 10;

   // mode code the block ignores
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  ack_seq;
      logic [WIN_W-1:0]  window;
      logic [TS_W-1:0]   echo_ts;
      logic              dropped;
      logic              dup;
      logic              removed;
      logic [SEQ_W-1:0]  removed_seq;
   } ack_result_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  csr_we     = 1'b0;
   logic [SEQ_W-1:0]      csr_wdata  = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = MODE_PROBE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;

   // predicted ring state
   logic             win_valid [SLOTS];
   logic [SEQ_W-1:0] win_seq [SLOTS];
   int unsigned      head_ptr;
   int unsigned      tail_ptr;
   int unsigned      ack_ptr;
   int unsigned      free_cnt;
   logic [SEQ_W-1:0] next_expected;

   ack_result_type pending_acks [$];

   int  req_idle_pct;
   int  rsp_idle_pct;
   bit  rsp_hold_req;
   int  rsp_hold_left;
   int  fail_count;
   int  items_sent;
   int  results_checked;
   int  cfg_writes;
   int  stall_cycles;

   reorder_window_cumulative_ack #(
      .WINDOW_SLOTS(SLOTS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [WIN_W-1:0] window_room();
      longint gap;
      longint room;
      if (!win_valid[tail_ptr]) begin
         return WIN_W'(SLOTS);
      end
      gap  = longint'(next_expected) - longint'(win_seq[tail_ptr]);
      room = longint'(SLOTS) - gap;
      if (room < 0) room = 0;
      if (room > SLOTS) room = SLOTS;
      return WIN_W'(room);
   endfunction

   task automatic advance_ack_ptr();
      int unsigned steps;
      bit          done;
      steps = 0;
      done  = 1'b0;
      while (!done && steps < SLOTS && win_valid[ack_ptr]) begin
         next_expected = win_seq[ack_ptr] + 1'b1;
         ack_ptr = (ack_ptr + 1) % SLOTS;
         steps++;
         // a full window moves the pointer one slot only
         if (free_cnt == 0) done = 1'b1;
      end
   endtask

   task automatic place_slot(input int unsigned idx, input logic [SEQ_W-1:0] seq);
      win_valid[idx] = 1'b1;
      win_seq[idx]   = seq;
   endtask

   task automatic predict_ack(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] seq,
                              input logic [TS_W-1:0] ts);
      ack_result_type   res;
      logic [SEQ_W-1:0] hseq;
      int unsigned      delta;
      int unsigned      back;
      int unsigned      idx;
      res = '0;
      case (mode)
         MODE_DATA: begin
            res.kind    = KIND_ACK;
            res.echo_ts = ts;
            if (free_cnt >= SLOTS) begin
               // empty window takes the arrival after head whatever its number
               head_ptr = (head_ptr + 1) % SLOTS;
               place_slot(head_ptr, seq);
               free_cnt = SLOTS - 1;
               advance_ack_ptr();
            end else begin
               hseq = win_seq[head_ptr];
               if (seq > hseq) begin
                  delta = seq - hseq;
                  if (delta > free_cnt) begin
                     res.dropped = 1'b1;
                  end else begin
                     free_cnt -= delta;
                     head_ptr = (head_ptr + delta) % SLOTS;
                     place_slot(head_ptr, seq);
                     advance_ack_ptr();
                  end
               end else if (seq < next_expected) begin
                  res.dup = 1'b1;
                  advance_ack_ptr();
               end else begin
                  back = (hseq - seq) % SLOTS;
                  idx  = (head_ptr + SLOTS - back) % SLOTS;
                  if (!win_valid[idx]) place_slot(idx, seq);
                  advance_ack_ptr();
               end
            end
         end
         MODE_CONSUME: begin
            res.kind = KIND_CONSUME;
            if (free_cnt < SLOTS) begin
               res.removed     = 1'b1;
               res.removed_seq = win_valid[tail_ptr] ? win_seq[tail_ptr] : '0;
               win_valid[tail_ptr] = 1'b0;
               tail_ptr = (tail_ptr + 1) % SLOTS;
               free_cnt++;
            end
         end
         MODE_PROBE: begin
            res.kind = KIND_PROBE;
         end
         default: begin
            return;
         end
      endcase
      res.ack_seq = next_expected;
      res.window  = window_room();
      pending_acks.push_back(res);
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] seq,
                            input logic [TS_W-1:0] ts);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, ts, seq};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_ack(mode, seq, ts);
      items_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_acks.size() != 0) @(posedge clock);
   endtask

   task automatic write_initial_seq(input logic [SEQ_W-1:0] value);
      wait_drained();
      // an ignored-mode item may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we        <= 1'b0;
      next_expected = value;
      cfg_writes++;
   endtask

   task automatic drain_window();
      while (free_cnt < SLOTS) send_item(MODE_CONSUME, SEQ_W'($urandom()), $urandom());
   endtask

   task automatic pick_item(input int unsigned cons_pct, output logic [MODE_W-1:0] mode,
                            output logic [SEQ_W-1:0] seq);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      seq  = SEQ_W'($urandom());
      if (roll < 2) begin
         mode = MODE_UNUSED;
      end else if (roll < 10) begin
         mode = MODE_PROBE;
      end else if (roll < 10 + cons_pct) begin
         mode = MODE_CONSUME;
      end else begin
         mode = MODE_DATA;
         roll = $urandom_range(0, 99);
         // mostly arrivals near the window edge, some far ones
         if (free_cnt >= SLOTS) begin
            seq = next_expected + SEQ_W'($urandom_range(0, 3));
         end else if (roll < 60) begin
            seq = next_expected + SEQ_W'($urandom_range(0, 15));
         end else if (roll < 75) begin
            seq = win_seq[head_ptr] + SEQ_W'($urandom_range(1, 20));
         end else if (roll < 85) begin
            seq = next_expected - SEQ_W'($urandom_range(1, 5));
         end else if (roll < 90) begin
            seq = win_seq[head_ptr];
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver

   always @(posedge clock) begin
      ack_result_type got;
      ack_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind        = rsp_tuser;
         got.ack_seq     = rsp_tdata[SEQ_W-1:0];
         got.window      = rsp_tdata[OFS_WIN +: WIN_W];
         got.echo_ts     = rsp_tdata[OFS_ECHO +: TS_W];
         got.dropped     = rsp_tdata[OFS_DROP];
         got.dup         = rsp_tdata[OFS_DUP];
         got.removed     = rsp_tdata[OFS_REMOVED];
         got.removed_seq = rsp_tdata[OFS_RSEQ +: SEQ_W];
         if (pending_acks.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("[%0t] unexpected reply, kind %0d ack_seq %0d", $realtime,
                        got.kind, got.ack_seq);
         end else begin
            want = pending_acks.pop_front();
            results_checked++;
            if (got.kind != want.kind || got.ack_seq != want.ack_seq ||
                got.window != want.window || got.echo_ts != want.echo_ts ||
                got.dropped != want.dropped || got.dup != want.dup ||
                got.removed != want.removed || got.removed_seq != want.removed_seq) begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("[%0t] mismatch exp kind %0d ack %0d win %0d ts %h",
                           $realtime, want.kind, want.ack_seq, want.window, want.echo_ts);
                  $display("             exp drop %b dup %b rm %b rseq %0d",
                           want.dropped, want.dup, want.removed, want.removed_seq);
                  $display("             got kind %0d ack %0d win %0d ts %h",
                           got.kind, got.ack_seq, got.window, got.echo_ts);
                  $display("             got drop %b dup %b rm %b rseq %0d",
                           got.dropped, got.dup, got.removed, got.removed_seq);
               end
            end
         end
      end
      if (rsp_hold_req) begin
         rsp_hold_left = HOLD_CYCLES;
         rsp_hold_req  = 1'b0;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
      end
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[%0t] no progress for %0d cycles", $realtime, STALL_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic test_probe_and_empty_consume();
      send_item(MODE_PROBE, '0, '0);
      send_item(MODE_CONSUME, '1, '1);
      send_item(MODE_UNUSED, SEQ_W'($urandom()), $urandom());
   endtask

   task automatic test_reorder_and_flags();
      send_item(MODE_DATA, 31'd111, 32'h0000_0000);
      send_item(MODE_DATA, 31'd113, 32'hFFFF_FFFF);
      // fills the gap, ack jumps over both slots
      send_item(MODE_DATA, 31'd112, $urandom());
      send_item(MODE_DATA, 31'd112, $urandom());
      // too far beyond head for the free room
      send_item(MODE_DATA, 31'd133, $urandom());
      send_item(MODE_CONSUME, '0, '0);
      send_item(MODE_PROBE, '0, '0);
   endtask

   task automatic test_sequence_wrap();
      drain_window();
      write_initial_seq('1);
      send_item(MODE_DATA, '1, $urandom());
      send_item(MODE_DATA, '0, $urandom());
   endtask

   task automatic test_gap_consume();
      drain_window();
      write_initial_seq('0);
      send_item(MODE_DATA, 31'd0, $urandom());
      send_item(MODE_DATA, 31'd3, $urandom());
      send_item(MODE_DATA, 31'd2, $urandom());
      send_item(MODE_CONSUME, '0, '0);
      // tail now sits on a slot that was never filled
      send_item(MODE_CONSUME, '0, '0);
   endtask

   task automatic test_random_traffic(input int n, input int send_pct, input int recv_pct,
                                      input logic [SEQ_W-1:0] start_seq);
      logic [MODE_W-1:0] mode;
      logic [SEQ_W-1:0]  seq;
      int unsigned       cons_pct;
      // written with the window still occupied, so the window clamps get hit
      write_initial_seq(start_seq);
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      cons_pct     = 15;
      for (int i = 0; i < n; i++) begin
         if (i % 64 == 0) begin
            case ($urandom_range(0, 3))
               0: cons_pct = 4;
               1: cons_pct = 15;
               2: cons_pct = 30;
               default: cons_pct = 45;
            endcase
         end
         pick_item(cons_pct, mode, seq);
         send_item(mode, seq, $urandom());
      end
   endtask

   task automatic test_backpressure();
      logic [MODE_W-1:0] mode;
      logic [SEQ_W-1:0]  seq;
      req_idle_pct = 0;
      rsp_hold_req = 1'b1;
      for (int i = 0; i < 40; i++) begin
         pick_item(20, mode, seq);
         send_item(mode, seq, $urandom());
      end
      // sender goes quiet until every reply is back
      wait_drained();
      for (int i = 0; i < 10; i++) begin
         pick_item(20, mode, seq);
         send_item(mode, seq, $urandom());
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         win_valid[i] = 1'b0;
         win_seq[i]   = '0;
      end
      head_ptr        = SLOTS - 1;
      tail_ptr        = 0;
      ack_ptr         = 0;
      free_cnt        = SLOTS;
      next_expected   = INIT_EXPECTED_SEQ;
      req_idle_pct    = 22;
      rsp_idle_pct    = 49;
      rsp_hold_req    = 1'b0;
      rsp_hold_left   = 0;
      fail_count      = 0;
      items_sent      = 0;
      results_checked = 0;
      cfg_writes      = 0;
      stall_cycles    = 0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_probe_and_empty_consume();
      test_reorder_and_flags();
      test_sequence_wrap();
      test_gap_consume();
      test_random_traffic(520, 22, 49, INIT_EXPECTED_SEQ);
      test_random_traffic(520, 49, 22, 31'h7FFF_FFF0);
      test_random_traffic(520, 0, 0, SEQ_W'($urandom()));
      test_backpressure();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      fail_count += pending_acks.size();

      $display("run covered %0d items and %0d checked replies over %0d register writes,",
               items_sent, results_checked, cfg_writes);
      $display("with out-of-order arrivals, drops, duplicates, wrap and a long output stall");
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
